>>> design/assert_macros.svh
// Assertion macros used by the sync search controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> design/mas_pkg.sv
// Package: widths, header codes, lookup tables and control types of the sync search.
`default_nettype none

package mas_pkg;

  localparam int ByteW    = 8;
  localparam int WinW     = 24;
  localparam int HdrW     = 32;
  localparam int PosW     = 31;
  localparam int SpfW     = 11;
  localparam int KbpsW    = 9;
  localparam int BpsW     = 19;
  localparam int RateW    = 16;
  localparam int ModeW    = 2;
  localparam int FrameW   = 12;
  localparam int PadW     = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;
  localparam int ProdW    = SpfW + BpsW;
  localparam int DivSteps = ProdW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int FbShift  = 3;
  localparam int HdrBytes = 4;
  localparam int KbpsScale = 1000;

  localparam logic [PosW-1:0]    PosMax  = '1;
  localparam logic [10:0]        SyncOnes = 11'd2047;
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegStartOffset = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMatchRate   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegModeEnable  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegChannelMode = 2'd3;

  // Version field codes
  localparam logic [1:0] VerMpeg25   = 2'd0;
  localparam logic [1:0] VerReserved = 2'd1;
  localparam logic [1:0] VerMpeg2    = 2'd2;
  localparam logic [1:0] VerMpeg1    = 2'd3;

  // Layer field codes
  localparam logic [1:0] LayReserved = 2'd0;
  localparam logic [1:0] LayIII      = 2'd1;
  localparam logic [1:0] LayII       = 2'd2;
  localparam logic [1:0] LayI        = 2'd3;

  localparam logic [3:0] BriFree     = 4'd0;
  localparam logic [3:0] BriBad      = 4'd15;
  localparam logic [1:0] FriReserved = 2'd3;
  localparam logic [1:0] EmphReserved = 2'd2;

  localparam logic [SpfW-1:0] SpfLayI  = 11'd384;
  localparam logic [SpfW-1:0] SpfFull  = 11'd1152;
  localparam logic [SpfW-1:0] SpfHalf  = 11'd576;

  // kbps by [MPEG1][layer row: III, II, I][bitrate index]
  localparam logic [KbpsW-1:0] KbpsTab [0:1][0:2][0:15] = '{
    '{
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
    }
  };

  typedef struct packed {
    logic cap;
    logic bps_en;
    logic mul_en;
    logic div_en;
    logic load;
  } mas_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } mas_sts_t;

  function automatic logic header_ok(input logic [HdrW-1:0] h);
    header_ok = (h[31:21] == SyncOnes) && (h[20:19] != VerReserved) &&
                (h[18:17] != LayReserved) && (h[15:12] != BriFree) &&
                (h[15:12] != BriBad) && (h[11:10] != FriReserved) &&
                (h[1:0] != EmphReserved);
  endfunction

  function automatic logic [RateW-1:0] rate_hz(input logic [1:0] ver, input logic [1:0] fri);
    logic [RateW-1:0] base;
    base = '0;
    case (ver)
      VerMpeg25: base = 16'd11025;
      VerMpeg2:  base = 16'd22050;
      VerMpeg1:  base = 16'd44100;
      default:   base = '0;
    endcase
    case (fri)
      2'd0:    rate_hz = base;
      2'd1:    rate_hz = (ver == VerMpeg25) ? 16'd12000 :
                         (ver == VerMpeg2) ? 16'd24000 :
                         (ver == VerMpeg1) ? 16'd48000 : 16'd0;
      2'd2:    rate_hz = (ver == VerMpeg25) ? 16'd8000 :
                         (ver == VerMpeg2) ? 16'd16000 :
                         (ver == VerMpeg1) ? 16'd32000 : 16'd0;
      default: rate_hz = '0;
    endcase
  endfunction

  function automatic logic [KbpsW-1:0] kbps_lookup(input logic [1:0] ver,
                                                   input logic [1:0] lay,
                                                   input logic [3:0] bri);
    case (lay)
      LayIII:  kbps_lookup = KbpsTab[ver[0]][0][bri];
      LayII:   kbps_lookup = KbpsTab[ver[0]][1][bri];
      LayI:    kbps_lookup = KbpsTab[ver[0]][2][bri];
      default: kbps_lookup = '0;
    endcase
  endfunction

  function automatic logic [SpfW-1:0] spf_lookup(input logic [1:0] ver, input logic [1:0] lay);
    if (lay == LayI) begin
      spf_lookup = SpfLayI;
    end else if (lay == LayII || ver == VerMpeg1) begin
      spf_lookup = SpfFull;
    end else begin
      spf_lookup = SpfHalf;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/mas_if.sv
// Interfaces: byte request channel, result channel and configuration write channel.
`default_nettype none

interface mas_byte_if import mas_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             first_of_buffer;
  logic             last_of_buffer;

  modport source (output valid, data_byte, first_of_buffer, last_of_buffer, input ready);
  modport sink (input valid, data_byte, first_of_buffer, last_of_buffer, output ready);
endinterface

interface mas_result_if import mas_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [PosW-1:0]   header_position;
  logic [SpfW-1:0]   samples_per_frame;
  logic [BpsW-1:0]   bitrate_bps;
  logic [RateW-1:0]  sample_rate;
  logic [ModeW-1:0]  chan_mode;
  logic [FrameW-1:0] frame_bytes;

  modport source (output valid, found, header_position, samples_per_frame, bitrate_bps,
                  sample_rate, chan_mode, frame_bytes, input ready);
  modport sink (input valid, found, header_position, samples_per_frame, bitrate_bps,
                sample_rate, chan_mode, frame_bytes, output ready);
endinterface

interface mas_cfg_if import mas_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/mas_datapath.sv
// Datapath: byte window, header decode, match test, frame length multiply and divide.
`default_nettype none

module mas_datapath import mas_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mas_cmd_t            cmd,
  output mas_sts_t                 sts,
  input  wire logic [ByteW-1:0]    data_byte,
  input  wire logic                first_of_buffer,
  input  wire logic                last_of_buffer,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output logic                     found,
  output logic [PosW-1:0]          header_position,
  output logic [SpfW-1:0]          samples_per_frame,
  output logic [BpsW-1:0]          bitrate_bps,
  output logic [RateW-1:0]         sample_rate,
  output logic [ModeW-1:0]         chan_mode,
  output logic [FrameW-1:0]        frame_bytes
);

  logic [PosW-1:0]   start_offset;
  logic [RateW-1:0]  match_sample_rate;
  logic              match_mode_enable;
  logic [ModeW-1:0]  match_chan_mode;

  logic [WinW-1:0]   byte_window;
  logic [PosW-1:0]   byte_position;
  logic              search_done;

  logic              found_r;
  logic [PosW-1:0]   hp_r;
  logic [SpfW-1:0]   spf_r;
  logic [KbpsW-1:0]  kbps_r;
  logic [BpsW-1:0]   bps_r;
  logic [RateW-1:0]  rate_r;
  logic [ModeW-1:0]  mode_r;
  logic [PadW-1:0]   pad_r;
  logic [RateW-1:0]  rem;
  logic [ProdW-1:0]  dq;

  logic [WinW-1:0]   win_eff;
  logic [PosW-1:0]   pos_eff;
  logic              done_eff;
  logic [HdrW-1:0]   h;
  logic [PosW-1:0]   pos_next;
  logic [RateW-1:0]  rate;
  logic              rate_ok;
  logic              mode_ok;
  logic              hit;
  logic              miss;
  logic [PosW-1:0]   hp;
  logic [PadW-1:0]   pad_bytes;
  logic [RateW:0]    rem_sh;
  logic              q_bit;
  logic [RateW-1:0]  rem_next;
  logic [FrameW-1:0] frame;

  assign win_eff  = first_of_buffer ? '0 : byte_window;
  assign pos_eff  = first_of_buffer ? '0 : byte_position;
  assign done_eff = first_of_buffer ? 1'b0 : search_done;
  assign h        = {win_eff, data_byte};
  assign pos_next = (pos_eff == PosMax) ? pos_eff : pos_eff + PosW'(1);
  assign rate     = rate_hz(h[20:19], h[11:10]);
  assign rate_ok  = (match_sample_rate == '0) || (match_sample_rate == rate);
  assign mode_ok  = !match_mode_enable || (match_chan_mode == h[7:6]);
  assign hit      = !done_eff && (pos_next >= PosW'(HdrBytes)) && header_ok(h) &&
                    rate_ok && mode_ok && (rate != '0);
  assign miss     = !done_eff && !hit && last_of_buffer;
  assign hp       = start_offset + pos_next - PosW'(HdrBytes);
  assign pad_bytes = (h[18:17] == LayI) ? {h[9], 2'b00} : {2'b00, h[9]};

  assign sts.hit  = hit;
  assign sts.miss = miss;

  // One restoring step of the frame length division
  assign rem_sh   = {rem, dq[ProdW-1]};
  assign q_bit    = (rem_sh >= {1'b0, rate_r});
  assign rem_next = q_bit ? RateW'(rem_sh - {1'b0, rate_r}) : rem_sh[RateW-1:0];
  assign frame    = dq[FrameW+FbShift-1:FbShift] + FrameW'(pad_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset       <= '0;
      match_sample_rate  <= '0;
      match_mode_enable  <= 1'b0;
      match_chan_mode    <= '0;
      byte_window        <= '0;
      byte_position      <= '0;
      search_done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegStartOffset: start_offset       <= cfg_data[PosW-1:0];
          RegMatchRate:   match_sample_rate  <= cfg_data[RateW-1:0];
          RegModeEnable:  match_mode_enable  <= cfg_data[0];
          RegChannelMode: match_chan_mode    <= cfg_data[ModeW-1:0];
          default: ;
        endcase
      end
      if (cmd.cap) begin
        byte_window   <= h[WinW-1:0];
        byte_position <= pos_next;
        search_done   <= done_eff || hit || miss;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      found_r <= hit;
      hp_r    <= hp;
      spf_r   <= spf_lookup(h[20:19], h[18:17]);
      kbps_r  <= kbps_lookup(h[20:19], h[18:17], h[15:12]);
      rate_r  <= rate;
      mode_r  <= h[7:6];
      pad_r   <= pad_bytes;
    end
    if (cmd.bps_en) begin
      bps_r <= BpsW'(kbps_r) * BpsW'(KbpsScale);
    end
    if (cmd.mul_en) begin
      dq  <= ProdW'(spf_r) * ProdW'(bps_r);
      rem <= '0;
    end else if (cmd.div_en) begin
      dq  <= {dq[ProdW-2:0], q_bit};
      rem <= rem_next;
    end
    if (cmd.load) begin
      found             <= found_r;
      header_position   <= found_r ? hp_r : '0;
      samples_per_frame <= found_r ? spf_r : '0;
      bitrate_bps       <= found_r ? bps_r : '0;
      sample_rate       <= found_r ? rate_r : '0;
      chan_mode         <= found_r ? mode_r : '0;
      frame_bytes       <= found_r ? frame : '0;
    end
  end

endmodule

`default_nettype wire

>>> design/mas_ctrl.sv
// Controller: scan, frame length sequencing and result register handshake.
`default_nettype none
`include "assert_macros.svh"

module mas_ctrl import mas_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire mas_sts_t sts,
  output mas_cmd_t      cmd
);

  localparam logic [2:0] S_SCAN = 3'd0;
  localparam logic [2:0] S_BPS  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [DivCntW-1:0] cnt;
  logic [DivCntW-1:0] cnt_next;
  logic               out_valid_next;
  logic               slot_free;

  assign in_ready   = (state == S_SCAN);
  assign slot_free  = !out_valid || out_ready;
  assign cmd.cap    = in_valid && in_ready;
  assign cmd.bps_en = (state == S_BPS);
  assign cmd.mul_en = (state == S_MUL);
  assign cmd.div_en = (state == S_DIV);
  assign cmd.load   = (state == S_LOAD) && slot_free;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_SCAN: begin
        if (cmd.cap && sts.hit) begin
          state_next = S_BPS;
        end else if (cmd.cap && sts.miss) begin
          state_next = S_LOAD;
        end
      end
      S_BPS: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_DIV;
        cnt_next   = '0;
      end
      S_DIV: begin
        cnt_next = cnt + DivCntW'(1);
        if (cnt == DivLast) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (slot_free) begin
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_SCAN;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SCAN;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_RST(a_hit_starts_len, clk, rst, cmd.cap && sts.hit |=> state == S_BPS, "hit did not start frame length")
  `ASSERT_NEVER(a_hit_and_miss, clk, rst, sts.hit && sts.miss, "hit and miss raised together")
  `ASSERT_RST(a_div_ends, clk, rst, state == S_DIV && cnt == DivLast |=> state == S_LOAD, "divide overran")
  `ASSERT_RST(a_load_shows, clk, rst, cmd.load |=> out_valid, "loaded result not presented")

endmodule

`default_nettype wire

>>> design/mpeg_audio_sync_search.sv
// Top level of the MPEG audio sync search: controller, datapath and channel wiring.
// Usage:
//   stream : byte requests (data_byte, first_of_buffer, last_of_buffer), valid/ready.
//   result : at most one response per buffer (found, position, frame parameters).
//   cfg    : register writes by index, always ready; write only while the block is idle.
// A byte that does not end the search leaves stream.ready high, so bytes stream at one
// per cycle while no response is due. A byte that completes a header match holds
// stream.ready low through the bitrate scale, the samples x bitrate multiply, the
// one-bit-per-cycle restoring divide by the sample rate and the load of the result
// register. A not-found response on the last byte holds stream.ready low until it is
// loaded into the result register. The result register decouples the two sides: the
// block keeps taking bytes while a response waits, and only holds the next response
// (and stream.ready) until the previous one is taken.
// Reset (rst, synchronous) clears the registers, the window, position and done flag
// and drops result.valid.
`default_nettype none

module mpeg_audio_sync_search import mas_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  mas_byte_if.sink    stream,
  mas_result_if.source result,
  mas_cfg_if.sink     cfg
);

  mas_cmd_t cmd;
  mas_sts_t sts;

  assign cfg.ready = 1'b1;

  mas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mas_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .data_byte         (stream.data_byte),
    .first_of_buffer   (stream.first_of_buffer),
    .last_of_buffer    (stream.last_of_buffer),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .found             (result.found),
    .header_position   (result.header_position),
    .samples_per_frame (result.samples_per_frame),
    .bitrate_bps       (result.bitrate_bps),
    .sample_rate       (result.sample_rate),
    .chan_mode         (result.chan_mode),
    .frame_bytes       (result.frame_bytes)
  );

endmodule

`default_nettype wire

>>> test/tb_mpeg_audio_sync_search.sv
// Self-checking bench for the MPEG audio sync search: random byte buffers, scoreboarded results.
module tb_mpeg_audio_sync_search import mas_pkg::*;;

  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 235;
  localparam int NumPhases  = 8;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             first;
    logic             last;
  } stream_byte_t;

  typedef struct packed {
    logic              found;
    logic [PosW-1:0]   position;
    logic [SpfW-1:0]   spf;
    logic [BpsW-1:0]   bps;
    logic [RateW-1:0]  rate;
    logic [ModeW-1:0]  mode;
    logic [FrameW-1:0] frame_len;
  } frame_info_t;

  logic clk;
  logic rst;

  mas_byte_if   stream_if ();
  mas_result_if result_if ();
  mas_cfg_if    cfg_if ();

  mpeg_audio_sync_search dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  int unsigned kbps_tab [2][3][16] = '{
    '{
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}
    },
    '{
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
    }
  };

  int unsigned hz_tab [4][4] = '{
    '{11025, 12000, 8000, 0},
    '{0, 0, 0, 0},
    '{22050, 24000, 16000, 0},
    '{44100, 48000, 32000, 0}
  };

  int unsigned rate_menu [12] = '{0, 0, 0, 8000, 11025, 12000, 16000, 22050, 24000, 32000,
                                  44100, 48000};

  // Search state and register copies
  logic [WinW-1:0]     win_bytes  = '0;
  logic [PosW-1:0]     byte_count = '0;
  logic                done_flag  = 1'b0;
  logic [PosW-1:0]     offset_reg  = '0;
  logic [RateW-1:0]    rate_reg    = '0;
  logic                mode_en_reg = 1'b0;
  logic [ModeW-1:0]    mode_reg    = '0;

  stream_byte_t byte_queue [$];
  frame_info_t  expected_frames [$];
  stream_byte_t cur_byte;
  frame_info_t  pred_frame;
  frame_info_t  got_frame;
  frame_info_t  want_frame;

  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int frames_seen = 0;
  int cycle_count = 0;

  function automatic bit search_byte(input stream_byte_t it, output frame_info_t r);
    logic [31:0] h;
    logic [1:0]  ver, lay, fri, mode;
    logic [3:0]  bri;
    logic        pad;
    int unsigned hz, spf, bps;
    int          row;
    longint unsigned fb;
    r = '0;
    if (it.first) begin
      win_bytes = '0;
      byte_count = '0;
      done_flag = 1'b0;
    end
    h = {win_bytes, it.value};
    win_bytes = h[23:0];
    if (byte_count != PosMax) byte_count++;
    if (done_flag) return 1'b0;
    ver = h[20:19];
    lay = h[18:17];
    bri = h[15:12];
    fri = h[11:10];
    pad = h[9];
    mode = h[7:6];
    if (byte_count >= 4 && h[31:21] == SyncOnes && ver != VerReserved &&
        lay != LayReserved && bri != BriFree && bri != BriBad && fri != FriReserved &&
        h[1:0] != EmphReserved) begin
      row = lay - 1;
      hz = hz_tab[ver][fri];
      bps = kbps_tab[ver[0]][row][bri] * 1000;
      if (lay == LayI) spf = 384;
      else if (lay == LayII || ver == VerMpeg1) spf = 1152;
      else spf = 576;
      if ((rate_reg == 0 || rate_reg == hz) && (!mode_en_reg || mode_reg == mode) &&
          hz != 0) begin
        fb = (longint'(spf) * bps / hz) / 8 + ((lay == LayI) ? 4 * pad : pad);
        r.found = 1'b1;
        r.position = offset_reg + byte_count - 31'd4;
        r.spf = spf[SpfW-1:0];
        r.bps = bps[BpsW-1:0];
        r.rate = hz[RateW-1:0];
        r.mode = mode;
        r.frame_len = fb[FrameW-1:0];
        done_flag = 1'b1;
        return 1'b1;
      end
    end
    if (it.last) begin
      done_flag = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] hdr_word(input logic [1:0] ver, input logic [1:0] lay,
                                           input logic [3:0] bri, input logic [1:0] fri,
                                           input logic pad, input logic [1:0] mode,
                                           input logic [1:0] emph);
    hdr_word = {SyncOnes, ver, lay, 1'($urandom), bri, fri, pad, 1'($urandom), mode,
                4'($urandom), emph};
  endfunction

  function automatic logic [31:0] rand_header(input bit good);
    logic [31:0] w;
    logic [1:0]  ver, emph;
    int          pick;
    pick = $urandom_range(0, 2);
    ver = (pick == 0) ? VerMpeg25 : (pick == 1) ? VerMpeg2 : VerMpeg1;
    emph = 2'($urandom_range(0, 2));
    if (emph == EmphReserved) emph = 2'd3;
    w = hdr_word(ver, 2'($urandom_range(1, 3)), 4'($urandom_range(1, 14)),
                 2'($urandom_range(0, 2)), 1'($urandom), 2'($urandom), emph);
    if (!good) begin
      case ($urandom_range(0, 5))
        0: w[21 + $urandom_range(0, 10)] = 1'b0;
        1: w[20:19] = VerReserved;
        2: w[18:17] = LayReserved;
        3: w[15:12] = $urandom_range(0, 1) ? BriFree : BriBad;
        4: w[11:10] = FriReserved;
        default: w[1:0] = EmphReserved;
      endcase
    end
    return w;
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic first, input logic last);
    stream_byte_t it;
    it.value = value;
    it.first = first;
    it.last = last;
    byte_queue.push_back(it);
  endtask

  task automatic push_header(input logic [31:0] w, input logic first, input logic last);
    push_byte(w[31:24], first, 1'b0);
    push_byte(w[23:16], 1'b0, 1'b0);
    push_byte(w[15:8], 1'b0, 1'b0);
    push_byte(w[7:0], 1'b0, last);
  endtask

  task automatic add_buffer(output int count);
    logic [7:0]  bytes_q [$];
    logic [31:0] w;
    int          len, at, k;
    bit          drop_first, drop_last;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    for (k = 0; k < len; k++) begin
      bytes_q.push_back(($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom));
    end
    if (len >= 4) begin
      repeat ($urandom_range(0, 3)) begin
        w = rand_header($urandom_range(0, 3) != 0);
        at = $urandom_range(0, len - 4);
        bytes_q[at] = w[31:24];
        bytes_q[at + 1] = w[23:16];
        bytes_q[at + 2] = w[15:8];
        bytes_q[at + 3] = w[7:0];
      end
    end
    // broken framing now and then: missing start, missing end, stray end
    drop_first = ($urandom_range(0, 24) == 0);
    drop_last = ($urandom_range(0, 24) == 0);
    for (k = 0; k < len; k++) begin
      push_byte(bytes_q[k], k == 0 && !drop_first,
                (k == len - 1 && !drop_last) || $urandom_range(0, 59) == 0);
    end
    count = len;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      RegStartOffset: offset_reg = value[PosW-1:0];
      RegMatchRate:   rate_reg = value[RateW-1:0];
      RegModeEnable:  mode_en_reg = value[0];
      RegChannelMode: mode_reg = value[ModeW-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_queue.size() != 0 || stream_if.valid || expected_frames.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else begin
      if (stream_if.valid && stream_if.ready) begin
        if (search_byte(cur_byte, pred_frame)) expected_frames.push_back(pred_frame);
      end
      if (!stream_if.valid || stream_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          stream_if.valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          cur_byte = byte_queue.pop_front();
          stream_if.valid <= 1'b1;
          stream_if.data_byte <= cur_byte.value;
          stream_if.first_of_buffer <= cur_byte.first;
          stream_if.last_of_buffer <= cur_byte.last;
          if (idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 17);
        end else begin
          stream_if.valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the result side for a long stretch on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got_frame = {result_if.found, result_if.header_position, result_if.samples_per_frame,
                     result_if.bitrate_bps, result_if.sample_rate, result_if.chan_mode,
                     result_if.frame_bytes};
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with nothing expected", frames_seen);
        end else begin
          want_frame = expected_frames.pop_front();
          if (got_frame !== want_frame) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result %0d expected found=%0b pos=%0d spf=%0d bps=%0d hz=%0d mode=%0d len=%0d",
                       frames_seen, want_frame.found, want_frame.position, want_frame.spf,
                       want_frame.bps, want_frame.rate, want_frame.mode, want_frame.frame_len);
              $display("result %0d actual   found=%0b pos=%0d spf=%0d bps=%0d hz=%0d mode=%0d len=%0d",
                       frames_seen, got_frame.found, got_frame.position, got_frame.spf,
                       got_frame.bps, got_frame.rate, got_frame.mode, got_frame.frame_len);
            end
          end
        end
        frames_seen++;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 17);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int phase, phase_items, n, sel;
    logic [PosW-1:0]  so;
    logic [RateW-1:0] hz;
    stream_if.valid = 1'b0;
    stream_if.data_byte = '0;
    stream_if.first_of_buffer = 1'b0;
    stream_if.last_of_buffer = 1'b0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed buffers at reset settings
    push_header(hdr_word(VerMpeg1, LayI, 4'd14, 2'd2, 1'b1, 2'd3, 2'd0), 1'b1, 1'b1);
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFB, 1'b0, 1'b0);
    push_byte(8'h90, 1'b0, 1'b1);
    push_byte(8'h00, 1'b1, 1'b0);
    push_header(hdr_word(VerMpeg25, LayII, 4'd14, 2'd2, 1'b1, 2'd0, 2'd3), 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_header(hdr_word(VerMpeg2, LayIII, BriBad, 2'd0, 1'b0, 2'd1, 2'd0), 1'b1, 1'b1);
    push_header(hdr_word(VerMpeg2, LayIII, 4'd1, 2'd0, 1'b0, 2'd1, 2'd1), 1'b1, 1'b0);

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      if (phase == 0) begin
        so = PosMax;
        hz = 16'd48000;
        write_reg(RegModeEnable, CfgDataW'(1));
        write_reg(RegChannelMode, CfgDataW'(3));
      end else if (phase == 1) begin
        so = '0;
        hz = '0;
        write_reg(RegModeEnable, CfgDataW'(0));
        write_reg(RegChannelMode, CfgDataW'(0));
      end else begin
        sel = $urandom_range(0, 3);
        so = (sel == 0) ? '0 : (sel == 1) ? PosMax - PosW'($urandom_range(0, 40)) :
             (sel == 2) ? PosW'($urandom_range(0, 1000)) : PosW'($urandom);
        sel = $urandom_range(0, 12);
        hz = (sel == 12) ? RateW'($urandom_range(1, 48000)) : RateW'(rate_menu[sel]);
        write_reg(RegModeEnable, CfgDataW'($urandom_range(0, 2) == 0));
        write_reg(RegChannelMode, CfgDataW'($urandom_range(0, 3)));
      end
      write_reg(RegStartOffset, so);
      write_reg(RegMatchRate, CfgDataW'(hz));
      @(negedge clk);
      idle_en = (phase < NumPhases - 2);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        add_buffer(n);
        phase_items += n;
      end
      // stall the result side while bytes keep coming
      if (phase == 1) hold_req = 1'b1;
    end

    wait_idle();
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
